// ----- src/tsr_pkg.sv -----
// ----------------------------------------------------------------------------
// tsr_pkg
// shared types and constants of the timestamp record sorter
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int KEY_W       = 64;
    localparam int REC_W       = 64;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_RETURNED = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic [REC_W-1:0] rec;
        logic [KEY_W-1:0] key;
    } t_slot;

    typedef struct packed {
        logic load;
        logic pop;
    } t_cell_ctrl;

endpackage

// ----- src/timestamp_record_sorter.sv -----
// ----------------------------------------------------------------------------
// timestamp_record_sorter
// stable priority queue returning records in ascending timestamp order
// ----------------------------------------------------------------------------
// input beats on s_axis: tuser is the request (0 load, 1 pop), tdata holds
// the 32.32 timestamp in the low half and the record number in the high half.
// each input beat yields exactly one output beat on m_axis: tuser is the
// status (accepted, dropped full, returned, empty), tdata the returned
// timestamp and record number (zero unless returned), tlast marks a pop that
// leaves the store empty.
// the store is a row of MAX_RECORDS cells; a load compares its key against
// every cell at once and shifts the larger entries one place right, a pop
// shifts the whole row one place left. equal keys stay in arrival order.
// the output beat is registered, so it appears in the cycle after its input
// beat; one beat is taken every cycle while s_axis_tready is high, set by the
// single compare-and-shift step of the cell row. a stalled receiver holds the
// output register; s_axis_tready drops only while that register is full and m_axis_tready is low.
// reset empties the store at once by clearing the held count; no sweep.
// ----------------------------------------------------------------------------
module timestamp_record_sorter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // time_key, record_number
    input  logic [0:0]   s_axis_tuser,   // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // out_key, out_record
    output logic [1:0]   m_axis_tuser,   // status
    output logic         m_axis_tlast    // last
);

    localparam int N = tsr_pkg::MAX_RECORDS;

    logic [tsr_pkg::CNT_W-1:0] r_count;
    logic                      r_m_valid;
    tsr_pkg::t_status          r_m_status;
    tsr_pkg::t_slot            r_m_slot;
    logic                      r_m_last;

    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    tsr_pkg::t_cell_ctrl       w_ctrl;
    tsr_pkg::t_slot            w_new_slot;
    tsr_pkg::t_slot            w_slot [N];
    logic [N-1:0]              w_gt;
    logic [N-1:0]              w_occ;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == tsr_pkg::CNT_W'(N));
    assign w_empty       = (r_count == '0);
    assign w_new_slot    = s_axis_tdata;
    assign w_ctrl.load   = w_accept && (s_axis_tuser[0] == tsr_pkg::REQ_LOAD) && !w_full;
    assign w_ctrl.pop    = w_accept && (s_axis_tuser[0] == tsr_pkg::REQ_POP) && !w_empty;

    for (genvar g = 0; g < N; g++) begin : g_cell
        localparam logic [tsr_pkg::CNT_W-1:0] IDX = tsr_pkg::CNT_W'(g);
        logic           w_prev_occ;
        logic           w_prev_gt;
        tsr_pkg::t_slot w_prev_slot;
        tsr_pkg::t_slot w_next_slot;

        assign w_occ[g] = IDX < r_count;

        if (g == 0) begin : g_head
            assign w_prev_occ  = 1'b1;
            assign w_prev_gt   = 1'b0;
            assign w_prev_slot = w_new_slot;
        end else begin : g_body
            assign w_prev_occ  = w_occ[g-1];
            assign w_prev_gt   = w_gt[g-1];
            assign w_prev_slot = w_slot[g-1];
        end

        if (g == N - 1) begin : g_tail
            assign w_next_slot = w_slot[g];
        end else begin : g_inner
            assign w_next_slot = w_slot[g+1];
        end

        tsr_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_new_key   (w_new_slot.key),
            .i_new_slot  (w_new_slot),
            .i_occ       (w_occ[g]),
            .i_prev_occ  (w_prev_occ),
            .i_prev_gt   (w_prev_gt),
            .i_prev_slot (w_prev_slot),
            .i_next_slot (w_next_slot),
            .o_gt        (w_gt[g]),
            .o_slot      (w_slot[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_ctrl.load) begin
                r_count <= r_count + 1'b1;
            end else if (w_ctrl.pop) begin
                r_count <= r_count - 1'b1;
            end
            if (w_accept) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_slot <= '0;
            r_m_last <= 1'b0;
            priority if (s_axis_tuser[0] == tsr_pkg::REQ_LOAD) begin
                r_m_status <= w_full ? tsr_pkg::ST_DROPPED : tsr_pkg::ST_ACCEPTED;
            end else if (w_empty) begin
                r_m_status <= tsr_pkg::ST_EMPTY;
            end else begin
                r_m_status <= tsr_pkg::ST_RETURNED;
                r_m_slot   <= w_slot[0];
                r_m_last   <= (r_count == tsr_pkg::CNT_W'(1));
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_slot;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tlast  = r_m_last;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tsr_pkg::CNT_W'(N))
        else $error("held count exceeds capacity");

    a_load_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.load |=> r_count == $past(r_count) + 1'b1)
        else $error("load did not grow the store");

    a_pop_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.pop |=> r_count == $past(r_count) - 1'b1)
        else $error("pop did not shrink the store");

    a_quiet_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_status != tsr_pkg::ST_RETURNED) |->
            (r_m_slot == '0 && !r_m_last))
        else $error("non-return beat carries data");

endmodule

// ----- src/tsr_cell.sv -----
// ----------------------------------------------------------------------------
// tsr_cell
// one slot of the sorted chain: compares against the broadcast key and
// shifts right on insert or left on pop
// ----------------------------------------------------------------------------
module tsr_cell (
    input  logic                            i_clk,
    input  tsr_pkg::t_cell_ctrl             i_ctrl,
    input  logic [tsr_pkg::KEY_W-1:0]       i_new_key,
    input  tsr_pkg::t_slot                  i_new_slot,
    input  logic                            i_occ,
    input  logic                            i_prev_occ,
    input  logic                            i_prev_gt,
    input  tsr_pkg::t_slot                  i_prev_slot,
    input  tsr_pkg::t_slot                  i_next_slot,
    output logic                            o_gt,
    output tsr_pkg::t_slot                  o_slot
);

    tsr_pkg::t_slot r_slot;
    tsr_pkg::t_slot n_slot;
    logic           w_take_new;

    assign o_gt       = i_occ && (r_slot.key > i_new_key);
    assign w_take_new = i_prev_occ && !i_prev_gt && (!i_occ || o_gt);
    assign o_slot     = r_slot;

    always_comb begin
        n_slot = r_slot;
        priority if (i_ctrl.load) begin
            priority if (i_prev_gt) begin
                n_slot = i_prev_slot;
            end else if (w_take_new) begin
                n_slot = i_new_slot;
            end else begin
                n_slot = r_slot;
            end
        end else if (i_ctrl.pop) begin
            n_slot = i_next_slot;
        end else begin
            n_slot = r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule
